[src/kft_pkg.sv]
package kft_pkg;

    localparam int CAP   = 64;
    localparam int KEY_W = 32;
    localparam int CNT_W = 7;
    localparam int IDX_W = (CAP > 1) ? $clog2(CAP) : 1;
    localparam int CW    = $clog2(CAP + 1);

    typedef logic [CW-1:0]    cnt_t;
    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [KEY_W-1:0] key_t;
    typedef logic [CNT_W-1:0] cnt_port_t;

    typedef enum logic [1:0] {
        FN_INSERT = 2'd0,
        FN_REMOVE = 2'd1,
        FN_SET    = 2'd2,
        FN_QUERY  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_DUP     = 2'd2,
        ST_MISSING = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_CMP,
        PH_UPD
    } phase_t;

    // commands from the sequencer to every cell of the row
    typedef struct packed {
        logic cmp;
        logic ins;
        logic rem;
        logic set;
        logic flag;
    } cmd_t;

    // search answer from the row back to the sequencer
    typedef struct packed {
        logic found;
        logic flag;
    } find_t;

endpackage

[src/kft_cell.sv]
module kft_cell (
    input  logic             clk,
    input  logic             rst_n,
    input  kft_pkg::cmd_t    cmd,
    input  kft_pkg::key_t    op_key,
    input  logic             in_use,
    input  kft_pkg::key_t    prev_key,
    input  logic             prev_flag,
    input  kft_pkg::key_t    next_key,
    input  logic             next_flag,
    input  logic             rem_from,
    output kft_pkg::key_t    ent_key,
    output logic             ent_flag,
    output logic             hit
);

    kft_pkg::key_t key_reg;
    kft_pkg::key_t key_next;
    logic          flag_reg;
    logic          flag_next;
    logic          hit_reg;
    logic          hit_next;

    always_comb
    begin
        hit_next = hit_reg;
        if (cmd.cmp)
        begin
            hit_next = in_use && (key_reg == op_key);
        end
    end

    always_comb
    begin
        key_next  = key_reg;
        flag_next = flag_reg;
        if (cmd.ins)
        begin
            // whole row moves up one cell, new entry lands in cell zero
            key_next  = prev_key;
            flag_next = prev_flag;
        end
        else if (cmd.rem && rem_from)
        begin
            // cells from the hit upward pull down one place
            key_next  = next_key;
            flag_next = next_flag;
        end
        else if (cmd.set && hit_reg)
        begin
            flag_next = cmd.flag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else
        begin
            hit_reg <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        flag_reg <= flag_next;
    end

    assign ent_key  = key_reg;
    assign ent_flag = flag_reg;
    assign hit      = hit_reg;

endmodule

[src/kft_row.sv]
module kft_row (
    input  logic             clk,
    input  logic             rst_n,
    input  kft_pkg::cmd_t    cmd,
    input  kft_pkg::key_t    op_key,
    input  kft_pkg::cnt_t    count_cur,
    output kft_pkg::find_t   find
);

    kft_pkg::key_t              key_arr  [kft_pkg::CAP];
    logic [kft_pkg::CAP-1:0]    flag_vec;
    logic [kft_pkg::CAP-1:0]    hit_vec;
    logic [kft_pkg::CAP-1:0]    use_vec;
    logic [kft_pkg::CAP-1:0]    rem_vec;

    genvar gi;
    generate
        for (gi = 0; gi < kft_pkg::CAP; gi++)
        begin : g_cell
            kft_pkg::key_t prev_key;
            logic          prev_flag;
            kft_pkg::key_t next_key;
            logic          next_flag;

            assign use_vec[gi] = (32'(count_cur) > gi);
            // set for the hit cell and every cell above it
            assign rem_vec[gi] = |hit_vec[gi:0];

            if (gi == 0)
            begin : g_head
                assign prev_key  = op_key;
                assign prev_flag = 1'b0;
            end
            else
            begin : g_link
                assign prev_key  = key_arr[gi-1];
                assign prev_flag = flag_vec[gi-1];
            end

            if (gi == kft_pkg::CAP - 1)
            begin : g_tail
                assign next_key  = key_arr[gi];
                assign next_flag = flag_vec[gi];
            end
            else
            begin : g_down
                assign next_key  = key_arr[gi+1];
                assign next_flag = flag_vec[gi+1];
            end

            kft_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .cmd       (cmd),
                .op_key    (op_key),
                .in_use    (use_vec[gi]),
                .prev_key  (prev_key),
                .prev_flag (prev_flag),
                .next_key  (next_key),
                .next_flag (next_flag),
                .rem_from  (rem_vec[gi]),
                .ent_key   (key_arr[gi]),
                .ent_flag  (flag_vec[gi]),
                .hit       (hit_vec[gi])
            );
        end
    endgenerate

    // keys are unique, so at most one hit bit is set
    assign find.found = |hit_vec;
    assign find.flag  = |(hit_vec & flag_vec);

endmodule

[src/kft_ctrl.sv]
module kft_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            func,
    input  kft_pkg::key_t         key,
    input  logic                  flag_in,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [1:0]            status,
    output logic                  flag_out,
    output kft_pkg::cnt_port_t    count,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  kft_pkg::cnt_port_t    cfg_data,
    output kft_pkg::cmd_t         cmd,
    output kft_pkg::key_t         op_key,
    output kft_pkg::cnt_t         count_cur,
    input  kft_pkg::find_t        find
);

    kft_pkg::phase_t      phase_reg;
    kft_pkg::phase_t      phase_next;
    logic [1:0]           func_reg;
    kft_pkg::key_t        key_reg;
    logic                 flag_in_reg;
    kft_pkg::cnt_t        count_reg;
    kft_pkg::cnt_t        count_next;
    kft_pkg::cnt_port_t   limit_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    kft_pkg::status_t     status_reg;
    kft_pkg::status_t     status_next;
    logic                 flag_out_reg;
    logic                 flag_out_next;
    kft_pkg::cnt_t        count_out_reg;

    logic                 in_acc;
    logic                 out_free;
    logic                 upd_go;
    kft_pkg::cnt_t        limit_eff;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_acc    = in_valid && !in_stall;
    assign upd_go    = (phase_reg == kft_pkg::PH_UPD) && out_free;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        if (32'(limit_reg) > kft_pkg::CAP)
        begin
            limit_eff = kft_pkg::cnt_t'(kft_pkg::CAP);
        end
        else
        begin
            limit_eff = kft_pkg::cnt_t'(limit_reg);
        end
    end

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            kft_pkg::PH_IDLE:
            begin
                if (in_acc)
                begin
                    phase_next = kft_pkg::PH_CMP;
                end
            end
            kft_pkg::PH_CMP:
            begin
                phase_next = kft_pkg::PH_UPD;
            end
            kft_pkg::PH_UPD:
            begin
                if (out_free)
                begin
                    phase_next = in_acc ? kft_pkg::PH_CMP : kft_pkg::PH_IDLE;
                end
            end
            default:
            begin
                phase_next = kft_pkg::PH_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        in_stall      = !((phase_reg == kft_pkg::PH_IDLE) ||
                          ((phase_reg == kft_pkg::PH_UPD) && out_free));
        cmd           = '0;
        cmd.cmp       = (phase_reg == kft_pkg::PH_CMP);
        cmd.flag      = flag_in_reg;
        status_next   = status_reg;
        flag_out_next = flag_out_reg;
        count_next    = count_reg;
        if (upd_go)
        begin
            status_next   = kft_pkg::ST_OK;
            flag_out_next = 1'b0;
            case (kft_pkg::func_t'(func_reg))
                kft_pkg::FN_INSERT:
                begin
                    if (count_reg >= limit_eff)
                    begin
                        status_next = kft_pkg::ST_FULL;
                    end
                    else if (find.found)
                    begin
                        status_next = kft_pkg::ST_DUP;
                    end
                    else
                    begin
                        cmd.ins    = 1'b1;
                        count_next = count_reg + kft_pkg::cnt_t'(1);
                    end
                end
                kft_pkg::FN_REMOVE:
                begin
                    if (!find.found)
                    begin
                        status_next = kft_pkg::ST_MISSING;
                    end
                    else
                    begin
                        cmd.rem    = 1'b1;
                        count_next = count_reg - kft_pkg::cnt_t'(1);
                    end
                end
                kft_pkg::FN_SET:
                begin
                    if (!find.found)
                    begin
                        status_next = kft_pkg::ST_MISSING;
                    end
                    else
                    begin
                        cmd.set = 1'b1;
                    end
                end
                kft_pkg::FN_QUERY:
                begin
                    if (!find.found)
                    begin
                        status_next = kft_pkg::ST_MISSING;
                    end
                    else
                    begin
                        flag_out_next = find.flag;
                    end
                end
                default:
                begin
                    status_next = kft_pkg::ST_MISSING;
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (upd_go)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= kft_pkg::PH_IDLE;
            count_reg     <= '0;
            limit_reg     <= kft_pkg::cnt_port_t'(kft_pkg::CAP);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            func_reg    <= func;
            key_reg     <= key;
            flag_in_reg <= flag_in;
        end
        if (upd_go)
        begin
            status_reg    <= status_next;
            flag_out_reg  <= flag_out_next;
            count_out_reg <= count_next;
        end
    end

    assign op_key    = key_reg;
    assign count_cur = count_reg;
    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign flag_out  = flag_out_reg;
    assign count     = kft_pkg::cnt_port_t'(count_out_reg);

endmodule

[src/keyed_flag_table_unit.sv]
// each operation runs a compare phase across the cell row, then an update phase
// in which the row shifts or rewrites a cell and the result beat is registered;
// the update phase waits on out_stall, and the next operation is taken in it
// reset: entry count clears to zero and the capacity limit returns to 64;
// the key and flag cells are not cleared, slots at or above the count are unused
module keyed_flag_table_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  func,
    input  logic [31:0] key,
    input  logic        flag_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic        flag_out,
    output logic [6:0]  count,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data
);

    kft_pkg::cmd_t   cmd;
    kft_pkg::key_t   op_key;
    kft_pkg::cnt_t   count_cur;
    kft_pkg::find_t  find;

    kft_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .key       (key),
        .flag_in   (flag_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .flag_out  (flag_out),
        .count     (count),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .op_key    (op_key),
        .count_cur (count_cur),
        .find      (find)
    );

    kft_row u_row (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .op_key    (op_key),
        .count_cur (count_cur),
        .find      (find)
    );

endmodule

[sim/keyed_flag_table_checker.sv]
module keyed_flag_table_checker
    import kft_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  func,
    input  logic [31:0] key,
    input  logic        flag_in,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [1:0]  status,
    input  logic        flag_out,
    input  logic [6:0]  count,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [6:0]  cfg_data,
    output int          answers_pending,
    output int          mismatch_count
);

    typedef struct packed {
        status_t   st;
        logic      fl;
        cnt_port_t cnt;
    } table_answer_t;

    // shadow copy of the table
    key_t          shadow_keys [CAP];
    logic          shadow_flags[CAP];
    int            shadow_held;
    cnt_port_t     shadow_limit;
    table_answer_t answers_due[$];

    function automatic int find_slot(key_t k);
        for (int i = 0; i < shadow_held; i++)
        begin
            if (shadow_keys[i] == k)
                return i;
        end
        return -1;
    endfunction

    function automatic table_answer_t apply_op(func_t f, key_t k, logic fl);
        table_answer_t ans;
        int            slot;
        int            lim;
        lim    = (shadow_limit < CAP) ? int'(shadow_limit) : CAP;
        ans.st = ST_OK;
        ans.fl = 1'b0;
        slot   = find_slot(k);
        case (f)
            FN_INSERT:
            begin
                // full is checked ahead of duplicate
                if (shadow_held >= lim)
                    ans.st = ST_FULL;
                else if (slot >= 0)
                    ans.st = ST_DUP;
                else
                begin
                    shadow_keys[shadow_held]  = k;
                    shadow_flags[shadow_held] = 1'b0;
                    shadow_held++;
                end
            end
            FN_REMOVE:
            begin
                if (slot < 0)
                    ans.st = ST_MISSING;
                else
                begin
                    // last entry fills the hole
                    shadow_keys[slot]  = shadow_keys[shadow_held - 1];
                    shadow_flags[slot] = shadow_flags[shadow_held - 1];
                    shadow_held--;
                end
            end
            FN_SET:
            begin
                if (slot < 0)
                    ans.st = ST_MISSING;
                else
                    shadow_flags[slot] = fl;
            end
            FN_QUERY:
            begin
                if (slot < 0)
                    ans.st = ST_MISSING;
                else
                    ans.fl = shadow_flags[slot];
            end
        endcase
        ans.cnt = cnt_port_t'(shadow_held);
        return ans;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        table_answer_t want;
        if (!rst_n)
        begin
            shadow_held  = 0;
            shadow_limit = 7'd64;
            answers_due.delete();
            answers_pending = 0;
            mismatch_count  = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                shadow_limit = cfg_data;
            if (in_valid && !in_stall)
                answers_due.push_back(apply_op(func_t'(func), key, flag_in));
            if (out_valid && !out_stall)
            begin
                if (answers_due.size() == 0)
                begin
                    $display("%0t: result beat with none expected: status %0d flag %0d count %0d",
                             $time, status, flag_out, count);
                    mismatch_count++;
                end
                else
                begin
                    want = answers_due.pop_front();
                    if (status !== want.st)
                    begin
                        $display("%0t: status expected %0d got %0d", $time, want.st, status);
                        mismatch_count++;
                    end
                    if (flag_out !== want.fl)
                    begin
                        $display("%0t: flag_out expected %0d got %0d", $time, want.fl, flag_out);
                        mismatch_count++;
                    end
                    if (count !== want.cnt)
                    begin
                        $display("%0t: count expected %0d got %0d", $time, want.cnt, count);
                        mismatch_count++;
                    end
                end
            end
            answers_pending = answers_due.size();
        end
    end

endmodule

[sim/keyed_flag_table_unit_tb.sv]
module keyed_flag_table_unit_tb;
    import kft_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  func;
    logic [31:0] key;
    logic        flag_in;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  status;
    logic        flag_out;
    logic [6:0]  count;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [6:0]  cfg_data;

    int   answers_pending;
    int   mismatch_count;
    int   cycle_cnt = 0;
    int   ops_sent = 0;
    int   limits_written = 0;
    int   stall_left = 0;
    logic took_result = 1'b0;
    logic no_gaps = 1'b0;
    key_t key_pool[128];

    keyed_flag_table_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .key       (key),
        .flag_in   (flag_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .flag_out  (flag_out),
        .count     (count),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    keyed_flag_table_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .func            (func),
        .key             (key),
        .flag_in         (flag_in),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .flag_out        (flag_out),
        .count           (count),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .answers_pending (answers_pending),
        .mismatch_count  (mismatch_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("Mismatches found");
            $finish;
        end
    end

    // result side: a fresh stall length is drawn after every result beat
    always @(posedge clk)
        took_result <= out_valid && !out_stall;

    always @(negedge clk)
    begin
        if (took_result)
            stall_left = no_gaps ? 0 : $urandom_range(0, 8);
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
            out_stall <= 1'b0;
    end

    // called and returns at a falling edge; in_valid stays high after the beat
    task automatic send_op(func_t f, key_t k, logic fl);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 8);
        repeat (gap)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        func     <= f;
        key      <= k;
        flag_in  <= fl;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
        ops_sent++;
    endtask

    // drains the table pipeline before touching the limit
    task automatic set_limit(logic [6:0] v);
        in_valid <= 1'b0;
        while (answers_pending != 0)
            @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        limits_written++;
    endtask

    task automatic run_phase(logic [6:0] lim, int pool_n, int ins_w, logic quiet, int n);
        func_t f;
        key_t  k;
        set_limit(lim);
        no_gaps = quiet;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 99) < ins_w)
                f = FN_INSERT;
            else
            begin
                case ($urandom_range(0, 2))
                    0:       f = FN_REMOVE;
                    1:       f = FN_SET;
                    default: f = FN_QUERY;
                endcase
            end
            // mostly pool keys so hits and duplicates happen, some fresh noise
            if ($urandom_range(0, 9) == 0)
                k = $urandom;
            else
                k = key_pool[$urandom_range(0, pool_n - 1)];
            send_op(f, k, 1'($urandom_range(0, 1)));
        end
        no_gaps = 1'b0;
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        func      = FN_INSERT;
        key       = '0;
        flag_in   = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty table: the first three lookups miss, then inserts, a duplicate and hits
        send_op(FN_QUERY,  32'h0000_0000, 1'b0);
        send_op(FN_REMOVE, 32'hFFFF_FFFF, 1'b0);
        send_op(FN_SET,    32'h0000_0005, 1'b1);
        send_op(FN_INSERT, 32'h0000_0000, 1'b1);
        send_op(FN_INSERT, 32'hFFFF_FFFF, 1'b0);
        send_op(FN_INSERT, 32'h0000_0000, 1'b0);
        send_op(FN_SET,    32'hFFFF_FFFF, 1'b1);
        send_op(FN_QUERY,  32'hFFFF_FFFF, 1'b0);
        send_op(FN_QUERY,  32'h0000_0000, 1'b1);
        send_op(FN_INSERT, 32'hA5A5_A5A5, 1'b0);
        send_op(FN_INSERT, 32'h5A5A_5A5A, 1'b1);
        // removes the oldest entry; in the checker the last entry moves into slot zero
        send_op(FN_REMOVE, 32'h0000_0000, 1'b0);
        send_op(FN_QUERY,  32'hFFFF_FFFF, 1'b0);
        send_op(FN_QUERY,  32'h5A5A_5A5A, 1'b0);
        // full wins over duplicate
        set_limit(7'd3);
        send_op(FN_INSERT, 32'h0000_0001, 1'b0);
        send_op(FN_INSERT, 32'hFFFF_FFFF, 1'b0);
        // limit below the count keeps every entry
        set_limit(7'd2);
        send_op(FN_INSERT, 32'h0000_0002, 1'b0);
        send_op(FN_REMOVE, 32'hA5A5_A5A5, 1'b0);
        send_op(FN_INSERT, 32'h0000_0002, 1'b0);
        send_op(FN_REMOVE, 32'h5A5A_5A5A, 1'b0);
        send_op(FN_INSERT, 32'h1234_5678, 1'b1);
        set_limit(7'd0);
        send_op(FN_INSERT, 32'h8765_4321, 1'b0);
        send_op(FN_QUERY,  32'h1234_5678, 1'b0);

        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < 128; i++)
            key_pool[i] = $urandom;

        run_phase(7'd127, 96, 70, 1'b0, 150);
        run_phase(7'd10, 16, 40, 1'b1, 150);
        run_phase(7'd64, 96, 20, 1'b0, 150);
        run_phase(7'd1, 4, 50, 1'b0, 150);
        run_phase(7'd0, 8, 50, 1'b0, 100);
        run_phase(7'($urandom_range(2, 63)), 24, 45, 1'b0, 150);
        run_phase(7'd64, 128, 45, 1'b0, 200);
        run_phase(7'($urandom_range(65, 126)), 40, 50, 1'b1, 150);

        in_valid <= 1'b0;
        while (answers_pending != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);

        $display("ran %0d table operations over %0d capacity limit settings,",
                 ops_sent, limits_written);
        $display("with random gaps and stalls on both channels and some gap-free stretches");
        if (mismatch_count == 0 && answers_pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
